// ===== rtl/assert_macros.svh =====
// Assertion macros used by the pixel core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("%m failed");
`define ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error("%m failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, prop)
`define ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

// ===== rtl/fbp_pkg.sv =====
// Shared constants and types for the freeze blend pixel core.
package fbp_pkg;
  localparam int ChBits = 16;
  localparam int QBits = 2 * ChBits;
  localparam int NumStages = ChBits + 4;
  localparam logic [ChBits-1:0] ChMax = {ChBits{1'b1}};
  typedef logic [ChBits-1:0] ch_t;

  // Sideband that follows each word down the pipe.
  typedef struct packed {
    ch_t  alpha;
    logic last;
  } side_t;
endpackage

// ===== rtl/fbp_channel.sv =====
// One color channel pipeline: restoring divide, saturate, opacity mix.
module fbp_channel (
  input  logic              clk_i,
  input  logic              en_i,
  input  fbp_pkg::ch_t      dst_i,
  input  fbp_pkg::ch_t      src_i,
  input  fbp_pkg::ch_t      op_i,
  output fbp_pkg::ch_t      res_o
);
  import fbp_pkg::*;

  localparam int Steps = QBits / 2;  // two quotient bits per stage

  // Divide stages: remainder, shifting dividend/quotient, two bits each.
  logic [ChBits:0]   rem_q [Steps+1];
  logic [QBits-1:0]  num_q [Steps+1];
  ch_t dn_q [Steps+1];
  ch_t dd_q [Steps+1];
  ch_t oo_q [Steps+1];

  // Stage 0: square and denominator.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= '0;
      num_q[0] <= QBits'(dst_i) * QBits'(dst_i);
      dn_q[0]  <= ChMax - src_i;
      dd_q[0]  <= dst_i;
      oo_q[0]  <= op_i;
    end
  end

  for (genvar k = 0; k < Steps; k++) begin : g_div
    logic [ChBits:0]  r1, r2;
    logic [QBits-1:0] n1, n2;
    always_comb begin
      r1 = {rem_q[k][ChBits-1:0], num_q[k][QBits-1]};
      n1 = {num_q[k][QBits-2:0], 1'b0};
      if (r1 >= {1'b0, dn_q[k]}) begin
        r1 = r1 - {1'b0, dn_q[k]};
        n1[0] = 1'b1;
      end
      r2 = {r1[ChBits-1:0], n1[QBits-1]};
      n2 = {n1[QBits-2:0], 1'b0};
      if (r2 >= {1'b0, dn_q[k]}) begin
        r2 = r2 - {1'b0, dn_q[k]};
        n2[0] = 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= r2;
        num_q[k+1] <= n2;
        dn_q[k+1]  <= dn_q[k];
        dd_q[k+1]  <= dd_q[k];
        oo_q[k+1]  <= oo_q[k];
      end
    end
  end

  // Saturate and pick effect result; form both mix products.
  ch_t eff;
  always_comb begin
    if (dn_q[Steps] == '0) eff = dd_q[Steps];
    else if (num_q[Steps][QBits-1:ChBits] != '0) eff = ChMax;
    else eff = num_q[Steps][ChBits-1:0];
  end
  logic [QBits-1:0] pa_q, pb_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q <= QBits'(dd_q[Steps]) * QBits'(ChMax - oo_q[Steps]);
      pb_q <= QBits'(oo_q[Steps]) * QBits'(eff);
    end
  end

  // Divide by 2^n-1 with rounding: s = x + half, q = (s + (s>>n) + 1) >> n.
  logic [QBits:0] sum_q;
  always_ff @(posedge clk_i) begin
    if (en_i) sum_q <= (QBits+1)'(pa_q) + (QBits+1)'(pb_q) + (QBits+1)'(ChMax >> 1);
  end
  logic [QBits+1:0] t;
  assign t = (QBits+2)'(sum_q) + (QBits+2)'(sum_q >> ChBits) + (QBits+2)'(1);
  assign res_o = t[QBits-1:ChBits];
endmodule

// ===== rtl/freeze_blend_pixel_core.sv =====
// Throughput: one pixel word per cycle while the output is not stalled; a
// 16-stage restoring divider (two quotient bits a stage) per channel sets the depth.
// Output stalls freeze the whole pipe; valid bits move with the data.
// Reset clears valid bits and sets opacity to full scale.
// Pipe stages: square, 16 divide, mix products and sum; final round is combinational.
module freeze_blend_pixel_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [fbp_pkg::ChBits-1:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: dest_red, dest_green, dest_blue, dest_alpha, src_red, src_green, src_blue
  input  logic [7*fbp_pkg::ChBits-1:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: blended_red, blended_green, blended_blue, blended_alpha
  output logic [4*fbp_pkg::ChBits-1:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  import fbp_pkg::*;
  `include "assert_macros.svh"

  localparam int Lat = NumStages - 1;

  ch_t op_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) op_q <= ChMax;
    else if (cfg_we_i) op_q <= cfg_wdata_i;
  end

  // Pipe advances unless the last stage holds a word that is not taken.
  logic en;
  logic [Lat-1:0] vld_q;
  assign en = !vld_q[Lat-1] || m_axis_tready;
  assign s_axis_tready = en;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
  end

  // Alpha and last ride along a shift line.
  side_t sd_q [Lat];
  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0] <= '{alpha: s_axis_tdata[3*ChBits +: ChBits], last: s_axis_tlast};
      for (int i = 1; i < Lat; i++) sd_q[i] <= sd_q[i-1];
    end
  end

  ch_t res [3];
  for (genvar c = 0; c < 3; c++) begin : g_ch
    fbp_channel u_ch (
      .clk_i (clk_i),
      .en_i  (en),
      .dst_i (s_axis_tdata[ChBits*c +: ChBits]),
      .src_i (s_axis_tdata[4*ChBits + ChBits*c +: ChBits]),
      .op_i  (op_q),
      .res_o (res[c])
    );
  end

  assign m_axis_tvalid = vld_q[Lat-1];
  assign m_axis_tdata  = {sd_q[Lat-1].alpha, res[2], res[1], res[0]};
  assign m_axis_tlast  = sd_q[Lat-1].last;

  `ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `ASSERT_IMPL(a_ready_when_empty, clk_i, rst_ni, !m_axis_tvalid |-> s_axis_tready)
  `ASSERT_NEXT(a_enter, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, vld_q[0])
endmodule
